// ===== rtl/bshc_pkg.sv =====
// ----------------------------------------------------------------------------
// bshc_pkg
// Shared types and constants for the button-set twelve-hour clock.
// ----------------------------------------------------------------------------
`default_nettype none

package bshc_pkg;

    // Field widths
    localparam int unsigned BTN_W  = 5;
    localparam int unsigned TPS_W  = 10;
    localparam int unsigned DBT_W  = 8;
    localparam int unsigned HOUR_W = 4;
    localparam int unsigned MIN_W  = 6;
    localparam int unsigned SEC_W  = 6;

    // Stream and config port widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = TPS_W;

    // Button bit positions
    localparam int unsigned BTN_MINUTE = 0;
    localparam int unsigned BTN_SECOND = 1;
    localparam int unsigned BTN_DOWN   = 2;
    localparam int unsigned BTN_HOUR   = 3;
    localparam int unsigned BTN_UP     = 4;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS   = 2'd1;

    // Reset values and dial limits
    localparam logic [TPS_W-1:0]  TPS_RESET  = 10'd100;
    localparam logic [DBT_W-1:0]  DBT_RESET  = 8'd5;
    localparam logic [HOUR_W-1:0] HOUR_MIN   = 4'd1;
    localparam logic [HOUR_W-1:0] HOUR_MAX   = 4'd12;
    localparam logic [MIN_W-1:0]  MIN_MAX    = 6'd59;
    localparam logic [SEC_W-1:0]  SEC_MAX    = 6'd59;

    // Clock state
    typedef struct packed {
        logic [TPS_W-1:0]  divider;
        logic [BTN_W-1:0]  accepted;
        logic [DBT_W-1:0]  debounce;
        logic [TPS_W-1:0]  hold;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } clk_state_t;

    // Outcome of one tick
    typedef struct packed {
        clk_state_t nxt;
        logic       shown;
        logic       frozen;
    } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/bshc_step.sv =====
// ----------------------------------------------------------------------------
// bshc_step
// Next-state logic for one tick: debounce, hold repeat, setting and advance.
// ----------------------------------------------------------------------------
`default_nettype none

module bshc_step
    import bshc_pkg::*;
(
    input  wire logic [BTN_W-1:0] buttons,
    input  wire logic [TPS_W-1:0] ticks_per_second,
    input  wire logic [DBT_W-1:0] debounce_ticks,
    input  wire clk_state_t       cur,
    output step_res_t             res
);

    logic [TPS_W-1:0]  half;
    logic [TPS_W-1:0]  last;
    logic              do_set;
    logic              advance;
    logic [TPS_W-1:0]  div_mid;
    logic [HOUR_W-1:0] set_hour;
    logic [MIN_W-1:0]  set_minute;
    logic [SEC_W-1:0]  set_second;
    logic [HOUR_W-1:0] adv_hour;
    logic [MIN_W-1:0]  adv_minute;
    logic [SEC_W-1:0]  adv_second;

    assign half = ticks_per_second >> 1;
    assign last = ticks_per_second - 10'd1;

    // Field values after a button step (up wins over down)
    always_comb
    begin
        set_hour   = cur.hour;
        set_minute = cur.minute;
        set_second = cur.second;
        if (buttons[BTN_UP])
        begin
            if (buttons[BTN_HOUR])
                set_hour = (cur.hour >= HOUR_MAX) ? HOUR_MIN : cur.hour + 4'd1;
            if (buttons[BTN_MINUTE])
                set_minute = (cur.minute >= MIN_MAX) ? 6'd0 : cur.minute + 6'd1;
            if (buttons[BTN_SECOND])
                set_second = (cur.second >= SEC_MAX) ? 6'd0 : cur.second + 6'd1;
        end
        else if (buttons[BTN_DOWN])
        begin
            if (buttons[BTN_HOUR])
                set_hour = (cur.hour <= HOUR_MIN || cur.hour > HOUR_MAX) ?
                           HOUR_MAX : cur.hour - 4'd1;
            if (buttons[BTN_MINUTE])
                set_minute = (cur.minute == 6'd0 || cur.minute > MIN_MAX) ?
                             MIN_MAX : cur.minute - 6'd1;
            if (buttons[BTN_SECOND])
                set_second = (cur.second == 6'd0 || cur.second > SEC_MAX) ?
                             SEC_MAX : cur.second - 6'd1;
        end
    end

    // Field values after one second of running time
    always_comb
    begin
        adv_hour   = cur.hour;
        adv_minute = cur.minute;
        adv_second = cur.second;
        if (cur.second < SEC_MAX)
            adv_second = cur.second + 6'd1;
        else
        begin
            adv_second = 6'd0;
            if (cur.minute < MIN_MAX)
                adv_minute = cur.minute + 6'd1;
            else
            begin
                adv_minute = 6'd0;
                adv_hour   = (cur.hour >= HOUR_MAX) ? HOUR_MIN : cur.hour + 4'd1;
            end
        end
    end

    // Button handling and divider
    always_comb
    begin
        res        = '0;
        res.nxt    = cur;
        do_set     = 1'b0;
        res.frozen = 1'b0;

        if (buttons != '0)
        begin
            if (buttons == cur.accepted)
            begin
                if (cur.hold == ticks_per_second)
                begin
                    if ((cur.divider == half || cur.divider == last) &&
                        (buttons[BTN_UP] || buttons[BTN_DOWN]))
                        do_set = 1'b1;
                end
                else
                    res.nxt.hold = cur.hold + 10'd1;
            end
            else
            begin
                res.nxt.hold = '0;
                if (cur.debounce < debounce_ticks)
                begin
                    res.nxt.debounce = cur.debounce + 8'd1;
                    res.frozen       = 1'b1;
                end
                else
                begin
                    do_set           = 1'b1;
                    res.nxt.debounce = '0;
                    res.nxt.accepted = buttons;
                end
            end
        end

        advance = !res.frozen && (buttons == '0) && (cur.divider == ticks_per_second);
        div_mid = advance ? '0 : cur.divider;

        if (!res.frozen)
            res.nxt.divider = (div_mid < ticks_per_second) ? div_mid + 10'd1 : '0;

        if (do_set)
        begin
            res.nxt.hour   = set_hour;
            res.nxt.minute = set_minute;
            res.nxt.second = set_second;
        end
        else if (advance)
        begin
            res.nxt.hour   = adv_hour;
            res.nxt.minute = adv_minute;
            res.nxt.second = adv_second;
        end

        res.shown = do_set || advance;
    end

endmodule

`default_nettype wire

// ===== rtl/button_set_twelve_hour_clock.sv =====
// ----------------------------------------------------------------------------
// button_set_twelve_hour_clock
// Twelve-hour clock ticked by a stream of button words, set by buttons.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         one tick: buttons
//  m_*       out        time and display_update, one per tick
//  cfg_*     in         register writes (0 ticks_per_second, 1 debounce_ticks)
//
// One tick per cycle while m_tready stays high; each tick passes the input
// register, then the clock state and result register are updated together.
// Reset: time 12:00:00, counters clear, registers 100 and 5.
// A stalled result holds; the input register still takes one more request.
// ----------------------------------------------------------------------------
`default_nettype none

module button_set_twelve_hour_clock
    import bshc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [4:0] buttons
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // [3:0] hours, [9:4] minutes,
                                                   // [15:10] seconds,
                                                   // [16] display_update
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [TPS_W-1:0]  tps_reg;
    logic [DBT_W-1:0]  dbt_reg;
    logic              in_valid_reg;
    logic [BTN_W-1:0]  in_btn_reg;
    logic              out_valid_reg;
    logic [HOUR_W-1:0] out_hour_reg;
    logic [MIN_W-1:0]  out_min_reg;
    logic [SEC_W-1:0]  out_sec_reg;
    logic              out_upd_reg;
    clk_state_t        state_reg;
    clk_state_t        state_next;
    step_res_t         res;
    logic              fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
            dbt_reg <= DBT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_TICKS_PER_SECOND: tps_reg <= cfg_wdata;
                REG_DEBOUNCE_TICKS:   dbt_reg <= cfg_wdata[DBT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Handshake
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_btn_reg <= s_tdata[BTN_W-1:0];
    end

    bshc_step u_step (
        .buttons          (in_btn_reg),
        .ticks_per_second (tps_reg),
        .debounce_ticks   (dbt_reg),
        .cur              (state_reg),
        .res              (res)
    );

    assign state_next = fire ? res.nxt : state_reg;

    // Clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{divider: '0, accepted: '0, debounce: '0, hold: '0,
                           hour: HOUR_MAX, minute: '0, second: '0};
        else
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_hour_reg <= res.nxt.hour;
            out_min_reg  <= res.nxt.minute;
            out_sec_reg  <= res.nxt.second;
            out_upd_reg  <= res.shown;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_upd_reg, out_sec_reg, out_min_reg, out_hour_reg};

`ifndef SYNTHESIS
    // Held time always lies on the dial
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hour >= HOUR_MIN && state_reg.hour <= HOUR_MAX &&
        state_reg.minute <= MIN_MAX && state_reg.second <= SEC_MAX)
        else $error("clock state off the dial");

    // A debounce wait leaves divider and time untouched
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.frozen |=> $stable(state_reg.divider) &&
        $stable(state_reg.hour) && $stable(state_reg.minute) &&
        $stable(state_reg.second))
        else $error("state moved during debounce wait");

    // Input only stalls with both stages full
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without cause");

    // State moves only on a processed tick
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("state changed without a tick");
`endif

endmodule

`default_nettype wire
